>>> rtl/binomial_option_pricer_unit_defines.svh
// Assertion macros for the binomial option pricer checker.
`ifndef BINOMIAL_OPTION_PRICER_UNIT_DEFINES_SVH
`define BINOMIAL_OPTION_PRICER_UNIT_DEFINES_SVH

// Same-edge implication, off while reset is asserted.
`define BOP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-edge implication, off while reset is asserted.
`define BOP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bop_pkg.sv
// Shared constants, types and arithmetic helpers of the binomial option pricer.
package bop_pkg;

    localparam int MAX_STEPS  = 512;
    localparam int IDX_W      = $clog2(MAX_STEPS + 1);
    localparam int IND_LAT    = 3;
    localparam int CNT_W      = $clog2(MAX_STEPS + IND_LAT + 1);
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 30;
    localparam int PROB_W     = 31;
    localparam int STEP_W     = 10;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_UP_FACTOR   = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_DOWN_FACTOR = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_UP_PROB     = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_DISC   = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_COUNT  = CFG_ADDR_W'(4);

    localparam logic [DATA_W-1:0] Q30_ONE  = 32'h4000_0000;
    localparam logic [DATA_W-1:0] Q30_HALF = 32'h2000_0000;

    // Broadcast control for the row of node cells.
    typedef struct packed {
        logic              shift;
        logic              ins_en;
        logic [IDX_W-1:0]  ins_addr;
        logic [DATA_W-1:0] ins_data;
    } t_cell_ctrl;

    // Q2.30 product back to 32 bits: drop fraction, clamp at all ones.
    function automatic logic [DATA_W-1:0] sat_q30(input logic [2*DATA_W-1:0] prod);
        logic [DATA_W-1:0] res;
        if (|prod[2*DATA_W-1:DATA_W+FRAC_W]) begin
            res = '1;
        end else begin
            res = prod[DATA_W+FRAC_W-1:FRAC_W];
        end
        return res;
    endfunction

endpackage

>>> rtl/binomial_option_pricer_unit.sv
// Each item runs a leaf build and then backward induction; n = step count (max 512).
// Leaf build runs on the single leaf multiplier.
// Backward induction handles one node per cycle on a three-stage datapath.
// Throughput: one item at a time; the next item is taken the cycle after the result registers.
// Reset: synchronous, active low; clears control and restores register defaults.
// The node value row has no reset: every node is written before it is read.
module binomial_option_pricer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [bop_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bop_pkg::DATA_W-1:0]      i_cfg_wr_data,
    // Request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bop_pkg::DATA_W-1:0]      i_spot_price,
    input  logic [bop_pkg::DATA_W-1:0]      i_strike_price,
    input  logic                            i_is_call,
    // Result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bop_pkg::DATA_W-1:0]      o_option_price
);
    import bop_pkg::*;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;  // wait for an item
    localparam logic [1:0] ST_LEAF = 2'd1;  // build leaf payoffs into the row
    localparam logic [1:0] ST_IND  = 2'd2;  // step back one level at a time
    localparam logic [1:0] ST_FIN  = 2'd3;  // move the root into the result register

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] r_up_factor;
    logic [DATA_W-1:0] r_down_factor;
    logic [PROB_W-1:0] r_up_probability;
    logic [PROB_W-1:0] r_step_discount;
    logic [STEP_W-1:0] r_step_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_factor      <= Q30_ONE;
            r_down_factor    <= Q30_ONE;
            r_up_probability <= PROB_W'(Q30_HALF);
            r_step_discount  <= PROB_W'(Q30_ONE);
            r_step_count     <= STEP_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_UP_FACTOR:   r_up_factor      <= i_cfg_wr_data;
                REG_DOWN_FACTOR: r_down_factor    <= i_cfg_wr_data;
                REG_UP_PROB:     r_up_probability <= i_cfg_wr_data[PROB_W-1:0];
                REG_STEP_DISC:   r_step_discount  <= i_cfg_wr_data[PROB_W-1:0];
                REG_STEP_COUNT:  r_step_count     <= i_cfg_wr_data[STEP_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Per-item constants, latched at accept
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  steps_clamped;
    logic [PROB_W-1:0] prob_clamped;
    logic [IDX_W-1:0]  r_n;
    logic [PROB_W-1:0] r_p;
    logic [PROB_W-1:0] r_q;

    // Clamp step count to the row size and p to one, so 1-p stays non-negative.
    assign steps_clamped = (32'(r_step_count) > 32'(MAX_STEPS)) ?
                           IDX_W'(MAX_STEPS) : IDX_W'(r_step_count);
    assign prob_clamped  = (r_up_probability > PROB_W'(Q30_ONE)) ?
                           PROB_W'(Q30_ONE) : r_up_probability;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [IDX_W-1:0] r_lvl;
    logic [IDX_W-1:0] n_lvl;
    logic [CNT_W-1:0] r_cyc;
    logic [CNT_W-1:0] n_cyc;
    logic             r_out_valid;
    logic [DATA_W-1:0] r_option_price;

    logic             in_accept;
    logic             out_load;
    logic             leaf_emit;
    logic             leaf_done;
    logic [DATA_W-1:0] leaf_payoff;
    logic             ind_issue;
    logic             ind_valid;
    logic [DATA_W-1:0] ind_value;
    logic [CNT_W-1:0] lvl_ext;
    logic             lvl_last_cyc;
    logic [CNT_W-1:0] addr_tail;
    logic [CNT_W-1:0] addr_late;
    logic [DATA_W-1:0] cell_val [0:MAX_STEPS];

    assign o_in_stall  = (r_state != ST_IDLE) || !i_rst_n;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_load    = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);

    assign lvl_ext      = CNT_W'(r_lvl);
    assign lvl_last_cyc = (r_cyc == lvl_ext + CNT_W'(IND_LAT - 1));
    // Level i reads V[j], V[j+1] from cells 0 and 1 while r_cyc is below i.
    assign ind_issue    = (r_state == ST_IND) && (r_cyc < lvl_ext);

    always_comb begin
        n_state = r_state;
        n_lvl   = r_lvl;
        n_cyc   = r_cyc;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_LEAF;
                end
            end
            ST_LEAF: begin
                if (leaf_done) begin
                    n_lvl = r_n;
                    n_cyc = '0;
                    // No backward steps: the root is the payoff at spot.
                    n_state = (r_n == '0) ? ST_FIN : ST_IND;
                end
            end
            ST_IND: begin
                if (lvl_last_cyc) begin
                    n_cyc = '0;
                    if (r_lvl == IDX_W'(1)) begin
                        n_state = ST_FIN;
                    end else begin
                        n_lvl = r_lvl - IDX_W'(1);
                    end
                end else begin
                    n_cyc = r_cyc + CNT_W'(1);
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lvl       <= '0;
            r_cyc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            r_cyc   <= n_cyc;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: per-item constants and the result register.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_n <= steps_clamped;
            r_p <= prob_clamped;
            r_q <= PROB_W'(Q30_ONE) - prob_clamped;
        end
        if (out_load) begin
            r_option_price <= cell_val[0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_option_price = r_option_price;

    // ------------------------------------------------------------------
    // Leaf generator
    // ------------------------------------------------------------------
    bop_leaf u_leaf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_accept),
        .i_spot    (i_spot_price),
        .i_strike  (i_strike_price),
        .i_is_call (i_is_call),
        .i_steps   (r_n),
        .i_up      (r_up_factor),
        .i_down    (r_down_factor),
        .o_emit    (leaf_emit),
        .o_payoff  (leaf_payoff),
        .o_done    (leaf_done)
    );

    // ------------------------------------------------------------------
    // Induction datapath
    // ------------------------------------------------------------------
    bop_induct u_induct (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ind_issue),
        .i_low   (cell_val[0]),
        .i_high  (cell_val[1]),
        .i_prob  (r_p),
        .i_comp  (r_q),
        .i_disc  (r_step_discount),
        .o_valid (ind_valid),
        .o_value (ind_value)
    );

    // ------------------------------------------------------------------
    // Row control
    // ------------------------------------------------------------------
    // Leaf phase: every payoff enters at cell n while the row shifts down,
    // so after n+1 payoffs leaf j sits in cell j.
    // Induction at level i: the row shifts while r_cyc is at most i. A result
    // for node j returns through the induction datapath; while the row still shifts it
    // enters at cell i-IND_LAT, afterwards straight at cell j. Either way node
    // j lands in cell j when the level ends.
    t_cell_ctrl cell_ctrl;

    assign addr_tail = lvl_ext - CNT_W'(IND_LAT);
    assign addr_late = r_cyc - CNT_W'(IND_LAT);

    always_comb begin
        cell_ctrl.shift    = 1'b0;
        cell_ctrl.ins_en   = 1'b0;
        cell_ctrl.ins_addr = r_n;
        cell_ctrl.ins_data = leaf_payoff;
        unique case (r_state)
            ST_LEAF: begin
                cell_ctrl.shift  = leaf_emit;
                cell_ctrl.ins_en = leaf_emit;
            end
            ST_IND: begin
                cell_ctrl.shift    = (r_cyc <= lvl_ext);
                cell_ctrl.ins_en   = ind_valid;
                cell_ctrl.ins_data = ind_value;
                cell_ctrl.ins_addr = (r_cyc > lvl_ext) ? addr_late[IDX_W-1:0]
                                                       : addr_tail[IDX_W-1:0];
            end
            default: ;  // hold the row
        endcase
    end

    // ------------------------------------------------------------------
    // Row of node cells
    // ------------------------------------------------------------------
    for (genvar k = 0; k <= MAX_STEPS; k++) begin : g_cell
        logic [DATA_W-1:0] next_value;
        if (k == MAX_STEPS) begin : g_end
            assign next_value = '0;
        end else begin : g_mid
            assign next_value = cell_val[k+1];
        end
        bop_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl),
            .i_index      (IDX_W'(k)),
            .i_next_value (next_value),
            .o_value      (cell_val[k])
        );
    end

endmodule

>>> rtl/bop_cell.sv
// One node cell of the value row: holds a node value, shifts toward cell 0, takes inserts.
module bop_cell (
    input  logic                        i_clk,
    input  bop_pkg::t_cell_ctrl         i_ctrl,
    input  logic [bop_pkg::IDX_W-1:0]   i_index,
    input  logic [bop_pkg::DATA_W-1:0]  i_next_value,
    output logic [bop_pkg::DATA_W-1:0]  o_value
);
    import bop_pkg::*;

    logic [DATA_W-1:0] r_value;

    // Insert wins over shift at the addressed cell.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins_en && (i_ctrl.ins_addr == i_index)) begin
            r_value <= i_ctrl.ins_data;
        end else if (i_ctrl.shift) begin
            r_value <= i_next_value;
        end
    end

    assign o_value = r_value;

endmodule

>>> rtl/bop_leaf.sv
// Leaf generator: walks spot*u^j*d^(n-j) on one shared Q2.30 multiplier and emits payoffs.
module bop_leaf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bop_pkg::DATA_W-1:0]  i_spot,
    input  logic [bop_pkg::DATA_W-1:0]  i_strike,
    input  logic                        i_is_call,
    input  logic [bop_pkg::IDX_W-1:0]   i_steps,
    input  logic [bop_pkg::DATA_W-1:0]  i_up,
    input  logic [bop_pkg::DATA_W-1:0]  i_down,
    output logic                        o_emit,
    output logic [bop_pkg::DATA_W-1:0]  o_payoff,
    output logic                        o_done
);
    import bop_pkg::*;

    logic              r_busy;
    logic              r_have;
    logic [IDX_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_j;
    logic              r_call;
    logic [DATA_W-1:0] r_up;
    logic [DATA_W-1:0] r_s;
    logic [DATA_W-1:0] r_strike;

    logic                step_idle;
    logic                more;
    logic                load_step;
    logic [DATA_W-1:0]   mul_a;
    logic [DATA_W-1:0]   mul_f;
    logic [2*DATA_W-1:0] mul_p;
    logic [DATA_W-1:0]   mul_q;

    assign step_idle = r_busy && (r_rem == '0);
    assign more      = (r_j <= CNT_W'(i_steps));
    assign load_step = step_idle && more;
    assign o_emit    = step_idle && r_have;
    assign o_done    = step_idle && !more;

    // Load cycles advance the up prefix; other cycles apply one down move.
    assign mul_a = load_step ? r_up : r_s;
    assign mul_f = load_step ? i_up : i_down;
    assign mul_p = (2*DATA_W)'(mul_a) * (2*DATA_W)'(mul_f);
    assign mul_q = sat_q30(mul_p);

    always_comb begin
        if (r_call) begin
            o_payoff = (r_s > r_strike) ? (r_s - r_strike) : '0;
        end else begin
            o_payoff = (r_strike > r_s) ? (r_strike - r_s) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_have <= 1'b0;
            r_rem  <= '0;
            r_j    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_have <= 1'b0;
            r_rem  <= '0;
            r_j    <= '0;
        end else if (r_busy) begin
            if (r_rem != '0) begin
                r_rem <= r_rem - IDX_W'(1);
            end else if (more) begin
                r_rem  <= i_steps - r_j[IDX_W-1:0];
                r_j    <= r_j + CNT_W'(1);
                r_have <= 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_up     <= i_spot;
            r_strike <= i_strike;
            r_call   <= i_is_call;
        end else if (r_busy) begin
            if (r_rem != '0) begin
                r_s <= mul_q;
            end else if (more) begin
                r_s  <= r_up;
                r_up <= mul_q;
            end
        end
    end

endmodule

>>> rtl/bop_induct.sv
// Backward induction datapath: p*V[j+1] + (1-p)*V[j], then discount, over three stages.
module bop_induct (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [bop_pkg::DATA_W-1:0]  i_low,
    input  logic [bop_pkg::DATA_W-1:0]  i_high,
    input  logic [bop_pkg::PROB_W-1:0]  i_prob,
    input  logic [bop_pkg::PROB_W-1:0]  i_comp,
    input  logic [bop_pkg::PROB_W-1:0]  i_disc,
    output logic                        o_valid,
    output logic [bop_pkg::DATA_W-1:0]  o_value
);
    import bop_pkg::*;

    localparam int PW = PROB_W + DATA_W;

    logic          r_v1;
    logic          r_v2;
    logic          r_v3;
    logic [PW-1:0] r_pa;
    logic [PW-1:0] r_qb;
    logic [DATA_W-1:0] r_t;
    logic [PW-1:0] r_prod;
    logic [PW-1:0] sum;

    // p plus (1-p) is at most one, so the sum never carries out.
    assign sum = r_pa + r_qb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa   <= PW'(i_prob) * PW'(i_high);
        r_qb   <= PW'(i_comp) * PW'(i_low);
        r_t    <= sum[DATA_W+FRAC_W-1:FRAC_W];
        r_prod <= PW'(r_t) * PW'(i_disc);
    end

    assign o_valid = r_v3;
    assign o_value = sat_q30((2*DATA_W)'(r_prod));

endmodule

>>> rtl/bop_checker.sv
// Port-level checker for the binomial option pricer, bound to the top level.
`include "binomial_option_pricer_unit_defines.svh"

module bop_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [bop_pkg::DATA_W-1:0]      o_option_price
);
    import bop_pkg::*;

    // Hold a stalled result and its value.
    `BOP_ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result valid dropped under stall")
    `BOP_ASSERT_NEXT(a_out_data_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_option_price), "result changed under stall")
    // An accepted item keeps the request side busy on the next cycle.
    `BOP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "second item taken while busy")
    // A result appears only out of a busy period.
    `BOP_ASSERT_NOW(a_result_from_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result without a busy period")

endmodule

bind binomial_option_pricer_unit bop_checker u_bop_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_option_price (o_option_price)
);

>>> tb/tb_binomial_option_pricer_unit.sv
// Self-checking testbench for the binomial option pricer with its own bit-exact price predictor.
`timescale 1ns / 1ps

module tb_binomial_option_pricer_unit;
    import bop_pkg::*;

    // Clock, reset and block ports
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [DATA_W-1:0]     cfg_wr_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [DATA_W-1:0]     spot_price;
    logic [DATA_W-1:0]     strike_price;
    logic                  is_call;
    logic                  out_valid;
    logic                  out_stall;
    logic [DATA_W-1:0]     option_price;

    // Predictor copy of the register file, at reset values
    logic [DATA_W-1:0]     up_factor_q30   = Q30_ONE;
    logic [DATA_W-1:0]     down_factor_q30 = Q30_ONE;
    logic [PROB_W-1:0]     up_prob_q30     = PROB_W'(Q30_HALF);
    logic [PROB_W-1:0]     step_disc_q30   = PROB_W'(Q30_ONE);
    logic [STEP_W-1:0]     tree_steps      = STEP_W'(1);

    // Prices still owed by the block, oldest first
    logic [DATA_W-1:0]     expected_prices[$];
    logic [DATA_W-1:0]     owed_price;

    int quotes_sent    = 0;
    int prices_checked = 0;
    int reg_writes     = 0;
    int fault_count    = 0;

    // Receiver pattern: a long hold-off count, else a random stall rate in percent
    int rx_hold_cycles = 0;
    int rx_stall_pct   = 0;

    binomial_option_pricer_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_spot_price   (spot_price),
        .i_strike_price (strike_price),
        .i_is_call      (is_call),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_option_price (option_price)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Price predictor
    // ------------------------------------------------------------------

    // Scale by a Q2.30 factor: truncate the fraction, clamp at all ones.
    function automatic logic [DATA_W-1:0] q30_scale(input logic [DATA_W-1:0] x,
                                                    input logic [DATA_W-1:0] f);
        logic [63:0] prod;
        prod = ({32'd0, x} * {32'd0, f}) >> FRAC_W;
        return (prod[63:32] != 32'd0) ? '1 : prod[31:0];
    endfunction

    // Root value of the tree under the current register copy.
    function automatic logic [DATA_W-1:0] price_option(input logic [DATA_W-1:0] spot,
                                                       input logic [DATA_W-1:0] strike,
                                                       input logic call);
        logic [DATA_W-1:0] row [0:MAX_STEPS];
        logic [DATA_W-1:0] leaf;
        logic [63:0]       acc;
        logic [63:0]       p_up;
        logic [63:0]       p_down;
        int                levels;
        levels = (tree_steps > MAX_STEPS) ? MAX_STEPS : int'(tree_steps);
        // Clamp p at one so the down weight never goes negative
        p_up   = (up_prob_q30 > Q30_ONE) ? 64'(Q30_ONE) : 64'(up_prob_q30);
        p_down = 64'(Q30_ONE) - p_up;
        // Leaf j: j up moves, then the down moves, clamping after each
        for (int j = 0; j <= levels; j++) begin
            leaf = spot;
            for (int k = 0; k < j; k++) leaf = q30_scale(leaf, up_factor_q30);
            for (int k = j; k < levels; k++) leaf = q30_scale(leaf, down_factor_q30);
            if (call) begin
                row[j] = (leaf > strike) ? leaf - strike : '0;
            end else begin
                row[j] = (strike > leaf) ? strike - leaf : '0;
            end
        end
        // Step back one level at a time; the weighted sum keeps 32 bits
        for (int i = levels; i > 0; i--) begin
            for (int j = 0; j < i; j++) begin
                acc    = p_up * {32'd0, row[j + 1]} + p_down * {32'd0, row[j]};
                row[j] = q30_scale(acc[61:30], {1'b0, step_disc_q30});
            end
        end
        return row[0];
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Write one register at a falling edge; mirror it into the predictor copy.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        case (addr)
            REG_UP_FACTOR:   up_factor_q30   = data;
            REG_DOWN_FACTOR: down_factor_q30 = data;
            REG_UP_PROB:     up_prob_q30     = data[PROB_W-1:0];
            REG_STEP_DISC:   step_disc_q30   = data[PROB_W-1:0];
            REG_STEP_COUNT:  tree_steps      = data[STEP_W-1:0];
            default: ;  // unmapped index: block ignores it
        endcase
        reg_writes++;
    endtask

    task automatic write_tree(input logic [DATA_W-1:0] u, input logic [DATA_W-1:0] d,
                              input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] disc,
                              input logic [DATA_W-1:0] steps);
        write_reg(REG_UP_FACTOR, u);
        write_reg(REG_DOWN_FACTOR, d);
        write_reg(REG_UP_PROB, p);
        write_reg(REG_STEP_DISC, disc);
        write_reg(REG_STEP_COUNT, steps);
    endtask

    // Offer one item and hold it until the block takes it. Valid stays high on
    // return so a back-to-back item needs no second assignment in one step.
    task automatic offer_quote(input logic [DATA_W-1:0] spot, input logic [DATA_W-1:0] strike,
                               input logic call);
        logic [DATA_W-1:0] fair;
        @(negedge clk);
        in_valid     <= 1'b1;
        spot_price   <= spot;
        strike_price <= strike;
        is_call      <= call;
        fair = price_option(spot, strike, call);
        do @(posedge clk); while (in_stall);
        expected_prices.push_back(fair);
        quotes_sent++;
    endtask

    // Drop valid for a gap of the given length.
    task automatic idle_sender(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Drop valid and wait until every owed price has come back.
    task automatic settle_quotes();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (expected_prices.size() == 0);
    endtask

    // Change the receiver's stall rate away from its falling-edge update.
    task automatic receiver_mode(input int pct);
        @(posedge clk);
        rx_stall_pct = pct;
    endtask

    // ------------------------------------------------------------------
    // Receiver and result check
    // ------------------------------------------------------------------

    // Stall on a pattern of its own: a counted hold-off wins, else random.
    always @(negedge clk) begin
        if (rx_hold_cycles > 0) begin
            out_stall <= 1'b1;
            rx_hold_cycles = rx_hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(1, 100) <= rx_stall_pct);
        end
    end

    // Compare each accepted price with the oldest owed one.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_prices.size() == 0) begin
                $error("option_price: result with no item pending, actual %h", option_price);
                fault_count++;
            end else begin
                owed_price = expected_prices.pop_front();
                if (option_price !== owed_price) begin
                    $error("option_price: expected %h, actual %h", owed_price, option_price);
                    fault_count++;
                end
            end
            prices_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: one step, u = d = 1, p = 0.5, no discount.
    task automatic test_reset_defaults();
        offer_quote(32'h0000_0000, 32'h0000_0000, 1'b1);
        offer_quote(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        offer_quote(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        offer_quote(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        offer_quote(32'h0064_0000, 32'h005A_0000, 1'b1);
        settle_quotes();
    endtask

    // Typical tree, the zero extremes of p and discount, unmapped indexes.
    task automatic test_register_writes();
        write_tree(32'h4147_AE14, 32'h3EC0_0000, 32'h2100_0000, 32'h3FFF_0000, 8);
        offer_quote(32'h0064_0000, 32'h0064_0000, 1'b1);
        offer_quote(32'h0064_0000, 32'h0064_0000, 1'b0);
        // Junk to every unmapped index must leave the tree as it is
        for (int a = int'(REG_STEP_COUNT) + 1; a < 2 ** CFG_ADDR_W; a++) begin
            settle_quotes();
            write_reg(CFG_ADDR_W'(a), 32'hFFFF_FFFF);
        end
        offer_quote(32'h0050_0000, 32'h0060_0000, 1'b0);
        settle_quotes();
        write_reg(REG_UP_PROB, 32'h0000_0000);
        offer_quote(32'h0064_0000, 32'h0050_0000, 1'b1);
        settle_quotes();
        write_reg(REG_STEP_DISC, 32'h0000_0000);
        offer_quote(32'h0064_0000, 32'h0078_0000, 1'b0);
        settle_quotes();
    endtask

    // Probability and discount above one, zero steps, step count past the maximum.
    task automatic test_special_cases();
        write_tree(32'h4100_0000, 32'h3F00_0000, 32'h7FFF_FFFF, 32'h3FF0_0000, 6);
        offer_quote(32'h0064_0000, 32'h0060_0000, 1'b1);
        settle_quotes();
        write_reg(REG_UP_PROB, 32'h4000_0001);
        offer_quote(32'h0064_0000, 32'h0068_0000, 1'b0);
        settle_quotes();
        // Discount near two doubles the value each level until it clamps
        write_tree(Q30_ONE, Q30_ONE, Q30_HALF, 32'h7FFF_FFFF, 4);
        offer_quote(32'hF000_0000, 32'h0000_0000, 1'b1);
        offer_quote(32'h0001_0000, 32'h0000_8000, 1'b1);
        settle_quotes();
        // Zero steps: the payoff at the spot itself
        write_reg(REG_STEP_COUNT, 32'h0000_0000);
        offer_quote(32'h0070_0000, 32'h0064_0000, 1'b1);
        offer_quote(32'h0070_0000, 32'h0080_0000, 1'b0);
        settle_quotes();
        // All-ones write lands as 1023 steps, clamped to the maximum; leaves
        // clamp on the way up and collapse on a zero down factor
        write_tree(32'hFFFF_FFFF, 32'h0000_0000, 32'h1000_0000, 32'h3FFF_FFF0, 32'hFFFF_FFFF);
        offer_quote(32'h0064_0000, 32'h0032_0000, 1'b1);
        settle_quotes();
    endtask

    // Full-depth tree with realistic factors.
    task automatic test_largest_tree();
        write_tree(32'h4020_0000, 32'h3FE0_0000, 32'h2010_0000, 32'h3FFF_F000, MAX_STEPS);
        offer_quote(32'h0064_0000, 32'h0064_0000, 1'b1);
        settle_quotes();
    endtask

    // Random tree settings per phase; bursty sender; stall rate varies per phase.
    task automatic test_random_pricing();
        logic [DATA_W-1:0] u, d, p, disc, steps, spot, strike;
        int                burst_left;
        for (int phase = 0; phase < 5; phase++) begin
            u     = Q30_ONE + $urandom_range(0, 32'h0400_0000);
            d     = Q30_ONE - $urandom_range(0, 32'h0400_0000);
            p     = $urandom_range(0, Q30_ONE);
            disc  = $urandom_range(Q30_ONE - 32'h0100_0000, Q30_ONE);
            steps = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) u = $urandom;
            if ($urandom_range(0, 3) == 0) d = $urandom;
            if ($urandom_range(0, 4) == 0) p = $urandom;
            if ($urandom_range(0, 4) == 0) disc = $urandom;
            if ($urandom_range(0, 4) == 0) steps = $urandom_range(11, 32);
            write_tree(u, d, p, disc, steps);
            receiver_mode((phase % 3) * 30);
            burst_left = 0;
            for (int k = 0; k < 20; k++) begin
                // Phase one runs without sender gaps
                if (burst_left == 0) begin
                    if (phase != 1) idle_sender($urandom_range(1, 10));
                    burst_left = $urandom_range(1, 6);
                end
                burst_left--;
                // Keep strike near spot most of the time so payoffs are live
                if ($urandom_range(0, 1) == 0) begin
                    spot = $urandom;
                end else begin
                    spot = $urandom_range(32'h0001_0000, 32'h0100_0000);
                end
                if ($urandom_range(0, 2) == 0) begin
                    strike = $urandom;
                end else begin
                    strike = spot + $urandom_range(0, spot >> 3) - (spot >> 4);
                end
                offer_quote(spot, strike, 1'($urandom_range(0, 1)));
            end
            settle_quotes();
        end
        receiver_mode(0);
    endtask

    // Hold the result port off long enough that the block stalls its input,
    // while the sender keeps offering.
    task automatic test_output_backpressure();
        write_tree(32'h4100_0000, 32'h3F00_0000, Q30_HALF, 32'h3FFF_0000, 1);
        @(posedge clk);
        rx_hold_cycles = 400;
        for (int k = 0; k < 5; k++) begin
            offer_quote($urandom, $urandom, k[0]);
        end
        settle_quotes();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = '0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        spot_price   = '0;
        strike_price = '0;
        is_call      = 1'b0;
        out_stall    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_writes();
        test_special_cases();
        test_largest_tree();
        test_random_pricing();
        test_output_backpressure();

        // Catch any stray result after the last one owed
        repeat (64) @(posedge clk);
        $display("Covered %0d items over %0d register writes, %0d prices checked:",
                 quotes_sent, reg_writes, prices_checked);
        $display("calls and puts, 0 to 1023 steps, clamped factors and output hold-off.");
        if (fault_count == 0 && expected_prices.size() == 0) begin
            $display("tb_binomial_option_pricer_unit OK");
        end else begin
            $display("tb_binomial_option_pricer_unit NOT OK");
        end
        $finish;
    end

    // Run limit: a few times the slowest correct run, two full-depth trees included
    initial begin
        #60_000_000;
        $display("tb_binomial_option_pricer_unit NOT OK");
        $finish;
    end

endmodule
